[rtl/core/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define CS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked outside reset
`define CS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/core/cossim_pkg.sv]
`default_nettype none

package cossim_pkg;

    localparam int MAX_ELEMENTS_DEFAULT = 16;

    localparam int ELEM_W      = 16;
    localparam int PROD_W      = 2 * ELEM_W;
    localparam int SUM_W       = 36;
    localparam int HALF_W      = SUM_W / 2;
    localparam int WIDE_W      = 2 * SUM_W;
    localparam int QUO_W       = 30;
    localparam int ROOT_W      = QUO_W / 2;
    localparam int SIM_W       = 16;
    localparam int QUEUE_DEPTH = 2;

    // 1.0 in q1.15
    localparam logic [SIM_W-1:0] SIM_ONE = 16'h8000;

    // one finished vector pair handed from front to back
    typedef struct packed {
        logic [SUM_W-1:0] dot;
        logic [SUM_W-1:0] norm_a;
        logic [SUM_W-1:0] norm_b;
    } sums_t;

endpackage

`default_nettype wire

[rtl/core/cossim_front.sv]
`default_nettype none

module cossim_front import cossim_pkg::*; #(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEFAULT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [ELEM_W-1:0] elem_a,
    input  wire logic [ELEM_W-1:0] elem_b,
    input  wire logic              last_pair,
    output logic                   push_valid,
    output sums_t                  push_data,
    input  wire logic              push_ready
);

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                                 input logic [PROD_W-1:0] v);
        logic [SUM_W:0] s;
        s = {1'b0, acc} + (SUM_W + 1)'(v);
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              p1_valid_reg;
    logic              p1_take_reg;
    logic              p1_last_reg;
    logic [PROD_W-1:0] pd_reg, pa_reg, pb_reg;
    logic [SUM_W-1:0]  dot_reg, na_reg, nb_reg;
    logic [SUM_W-1:0]  dot_add, na_add, nb_add;
    logic              accept, drain, take;

    assign drain    = p1_valid_reg && (!p1_last_reg || push_ready);
    assign s_tready = !p1_valid_reg || drain;
    assign accept   = s_tvalid && s_tready;
    assign take     = cnt_reg < CNT_W'(MAX_ELEMENTS);

    always_comb begin
        if (last_pair) begin
            cnt_next = '0;
        end else if (take) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else begin
            cnt_next = cnt_reg;
        end
    end

    assign dot_add = p1_take_reg ? sat_add(dot_reg, pd_reg) : dot_reg;
    assign na_add  = p1_take_reg ? sat_add(na_reg, pa_reg) : na_reg;
    assign nb_add  = p1_take_reg ? sat_add(nb_reg, pb_reg) : nb_reg;

    assign push_valid       = p1_valid_reg && p1_last_reg;
    assign push_data.dot    = dot_add;
    assign push_data.norm_a = na_add;
    assign push_data.norm_b = nb_add;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            cnt_reg      <= '0;
            dot_reg      <= '0;
            na_reg       <= '0;
            nb_reg       <= '0;
        end else begin
            if (accept) begin
                p1_valid_reg <= 1'b1;
                cnt_reg      <= cnt_next;
            end else if (drain) begin
                p1_valid_reg <= 1'b0;
            end
            if (drain) begin
                if (p1_last_reg) begin
                    dot_reg <= '0;
                    na_reg  <= '0;
                    nb_reg  <= '0;
                end else begin
                    dot_reg <= dot_add;
                    na_reg  <= na_add;
                    nb_reg  <= nb_add;
                end
            end
        end
    end

    // products for one pair
    always_ff @(posedge aclk) begin
        if (accept) begin
            pd_reg      <= PROD_W'(elem_a) * PROD_W'(elem_b);
            pa_reg      <= PROD_W'(elem_a) * PROD_W'(elem_a);
            pb_reg      <= PROD_W'(elem_b) * PROD_W'(elem_b);
            p1_take_reg <= take;
            p1_last_reg <= last_pair;
        end
    end

endmodule

`default_nettype wire

[rtl/core/cossim_queue.sv]
`default_nettype none

module cossim_queue import cossim_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push_valid,
    input  wire sums_t push_data,
    output logic       push_ready,
    output logic       pop_valid,
    output sums_t      pop_data,
    input  wire logic  pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

    sums_t            mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [LVL_W-1:0] level_reg;
    logic             do_push, do_pop;

    assign push_ready = level_reg != LVL_W'(QUEUE_DEPTH);
    assign pop_valid  = level_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   level_reg <= level_reg + LVL_W'(1);
                2'b01:   level_reg <= level_reg - LVL_W'(1);
                default: level_reg <= level_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[rtl/core/cossim_back.sv]
`default_nettype none

module cossim_back import cossim_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             job_valid,
    input  wire sums_t            job,
    output logic                  job_pop,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [SIM_W-1:0]      m_similarity,
    output logic                  m_undefined
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_SQRT  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    localparam int MUL_W  = 2 * HALF_W;
    localparam int STEP_W = $clog2(QUO_W);
    localparam int REM_W  = ROOT_W + 2;

    localparam logic [STEP_W-1:0] MUL_LAST  = STEP_W'(8);
    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(QUO_W - 1);
    localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(ROOT_W - 1);

    logic [2:0]        state_reg;
    logic [STEP_W-1:0] step_reg;
    logic [SUM_W-1:0]  dot_reg, na_reg, nb_reg;
    logic [MUL_W-1:0]  mult_reg;
    logic [WIDE_W-1:0] p_reg, d_reg;
    logic [WIDE_W-1:0] rem_reg;
    logic [QUO_W-1:0]  q_reg;
    logic [REM_W-1:0]  sq_rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [SIM_W-1:0]  res_sim_reg;
    logic              res_undef_reg;
    logic              m_valid_reg;
    logic [SIM_W-1:0]  m_sim_reg;
    logic              m_undef_reg;
    logic              out_load;

    // shared 18x18 multiplier, partial products of na*nb then dot*dot
    logic [2:0]        mul_idx, add_idx;
    logic [SUM_W-1:0]  x_src, y_src;
    logic [HALF_W-1:0] x_half, y_half;
    logic [MUL_W-1:0]  mul_next;
    logic [5:0]        shift_amt;
    logic [WIDE_W-1:0] shifted;

    assign mul_idx  = step_reg[2:0];
    assign add_idx  = step_reg[2:0] - 3'd1;
    assign x_src    = mul_idx[2] ? dot_reg : na_reg;
    assign y_src    = mul_idx[2] ? dot_reg : nb_reg;
    assign x_half   = mul_idx[1] ? x_src[SUM_W-1:HALF_W] : x_src[HALF_W-1:0];
    assign y_half   = mul_idx[0] ? y_src[SUM_W-1:HALF_W] : y_src[HALF_W-1:0];
    assign mul_next = MUL_W'(x_half) * MUL_W'(y_half);

    always_comb begin
        case (add_idx[1:0])
            2'd0:    shift_amt = 6'd0;
            2'd3:    shift_amt = 6'(2 * HALF_W);
            default: shift_amt = 6'(HALF_W);
        endcase
    end

    assign shifted = WIDE_W'(mult_reg) << shift_amt;

    // restoring division step for (dot^2 << 30) / (na*nb)
    logic [WIDE_W:0] div_shift, div_diff;
    logic            div_ge;

    assign div_shift = {rem_reg, 1'b0};
    assign div_ge    = div_shift >= {1'b0, p_reg};
    assign div_diff  = div_shift - {1'b0, p_reg};

    // square root, two radicand bits a step
    logic [REM_W+1:0]  sq_cur, sq_trial, sq_diff;
    logic              sq_ge;
    logic [ROOT_W-1:0] root_next;

    assign sq_cur    = {sq_rem_reg, q_reg[QUO_W-1 -: 2]};
    assign sq_trial  = (REM_W + 2)'({root_reg, 2'b01});
    assign sq_ge     = sq_cur >= sq_trial;
    assign sq_diff   = sq_cur - sq_trial;
    assign root_next = {root_reg[ROOT_W-2:0], sq_ge};

    assign job_pop      = (state_reg == ST_IDLE) && job_valid;
    assign out_load     = (state_reg == ST_OUT) && (!m_valid_reg || m_tready);
    assign m_tvalid     = m_valid_reg;
    assign m_similarity = m_sim_reg;
    assign m_undefined  = m_undef_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (job_valid) begin
                        state_reg <= ST_MUL;
                        step_reg  <= '0;
                    end
                end
                ST_MUL: begin
                    if (step_reg == MUL_LAST) begin
                        state_reg <= ST_CHECK;
                    end else begin
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                ST_CHECK: begin
                    step_reg <= '0;
                    if (na_reg == '0 || nb_reg == '0 || d_reg >= p_reg) begin
                        state_reg <= ST_OUT;
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (step_reg == DIV_LAST) begin
                        state_reg <= ST_SQRT;
                        step_reg  <= '0;
                    end else begin
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                ST_SQRT: begin
                    if (step_reg == SQRT_LAST) begin
                        state_reg <= ST_OUT;
                    end else begin
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                dot_reg <= job.dot;
                na_reg  <= job.norm_a;
                nb_reg  <= job.norm_b;
                p_reg   <= '0;
                d_reg   <= '0;
            end
            ST_MUL: begin
                mult_reg <= mul_next;
                if (step_reg != '0) begin
                    if (add_idx[2]) begin
                        d_reg <= d_reg + shifted;
                    end else begin
                        p_reg <= p_reg + shifted;
                    end
                end
            end
            ST_CHECK: begin
                rem_reg    <= d_reg;
                q_reg      <= '0;
                sq_rem_reg <= '0;
                root_reg   <= '0;
                if (na_reg == '0 || nb_reg == '0) begin
                    res_sim_reg   <= '0;
                    res_undef_reg <= 1'b1;
                end else begin
                    // dot^2 >= na*nb for parallel vectors or once sums saturate: cap at one
                    res_sim_reg   <= SIM_ONE;
                    res_undef_reg <= 1'b0;
                end
            end
            ST_DIV: begin
                rem_reg <= div_ge ? div_diff[WIDE_W-1:0] : div_shift[WIDE_W-1:0];
                q_reg   <= {q_reg[QUO_W-2:0], div_ge};
            end
            ST_SQRT: begin
                sq_rem_reg <= sq_ge ? sq_diff[REM_W-1:0] : sq_cur[REM_W-1:0];
                root_reg   <= root_next;
                q_reg      <= {q_reg[QUO_W-3:0], 2'b00};
                if (step_reg == SQRT_LAST) begin
                    res_sim_reg <= SIM_W'(root_next);
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    m_sim_reg   <= res_sim_reg;
                    m_undef_reg <= res_undef_reg;
                end
            end
            default: begin
                mult_reg <= mult_reg;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/cosine_similarity.sv]
// cosine similarity of two streamed vectors
//
// s_ channel: one element pair per word, a and b unsigned q4.12, s_tlast
// marks the final pair of the vectors. m_ channel: one word per vector
// pair, the cosine in unsigned q1.15 (0..32768) with m_tuser set when
// either norm is zero (the cosine then reads 0).
// only the first MAX_ELEMENTS pairs of a vector are summed; the sums
// saturate at 2^36-1 and a result pushed above one by that is capped.
// the front takes one pair per cycle unless a finished vector pair waits
// for room in the queue. after the last pair the result passes the
// accumulate/queue stage, the job pickup, the 18x18 partial products for
// na*nb and dot^2, the check, 30 division steps, 15 square root steps and
// the output load; a zero norm or a capped cosine skips division and root.
// the solver handles one vector pair at a time and takes the next only
// once its result is loaded; a 2-deep queue between front and solver
// lets the front run ahead by two vectors.
// reset (aresetn low, synchronous) clears the sums, the queue and any
// pending result. when m_tready stays low the result is held, the solver
// waits and the queue then the front fill up before s_tready drops.
`default_nettype none
`include "assert_macros.svh"

module cosine_similarity import cossim_pkg::*; #(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // elem_a [15:0], elem_b [31:16]
    input  wire logic        s_tlast,   // last_pair
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // similarity [15:0]
    output logic             m_tuser    // undefined
);

    logic  push_valid, push_ready;
    sums_t push_data;
    logic  job_valid, job_pop;
    sums_t job;

    cossim_front #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .elem_a     (s_tdata[ELEM_W-1:0]),
        .elem_b     (s_tdata[2*ELEM_W-1:ELEM_W]),
        .last_pair  (s_tlast),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    cossim_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (job_valid),
        .pop_data   (job),
        .pop        (job_pop)
    );

    cossim_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .job_valid    (job_valid),
        .job          (job),
        .job_pop      (job_pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_similarity (m_tdata),
        .m_undefined  (m_tuser)
    );

    // a zero norm always comes out as a zero cosine
    `CS_ASSERT_IMP(a_undef_zero, aclk, aresetn, m_tvalid && m_tuser, m_tdata == 16'd0)
    // the cosine never leaves 0..1
    `CS_ASSERT_IMP(a_sim_range, aclk, aresetn, m_tvalid, m_tdata <= SIM_ONE)
    // the solver only takes a job that is in the queue
    `CS_ASSERT_IMP(a_pop_valid, aclk, aresetn, job_pop, job_valid)
    // once a job is taken the solver is busy for the next cycle
    `CS_ASSERT_NXT(a_pop_busy, aclk, aresetn, job_pop, !job_pop)

endmodule

`default_nettype wire

[test/cosine_similarity_checker.sv]
`timescale 1ns / 100ps

module cosine_similarity_checker import cossim_pkg::*; #(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,    // elem_a [15:0], elem_b [31:16]
    input  logic        s_tlast,    // last_pair
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,    // similarity [15:0]
    input  logic        m_tuser,    // undefined
    output int          fail_count,
    output int          results_owed
);

    typedef struct packed {
        logic [SIM_W-1:0] similarity;
        logic             undefined;
    } cosine_t;

    cosine_t          cosine_due[$];
    cosine_t          got_word;
    cosine_t          want_word;
    logic [SUM_W-1:0] dot_acc;
    logic [SUM_W-1:0] norm_a_acc;
    logic [SUM_W-1:0] norm_b_acc;
    logic [SUM_W-1:0] prod_ab;
    logic [SUM_W-1:0] prod_aa;
    logic [SUM_W-1:0] prod_bb;
    logic [15:0]      a_elem;
    logic [15:0]      b_elem;
    int               pairs_summed;

    function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] acc,
                                                 input logic [SUM_W-1:0] add);
        logic [SUM_W:0] t;
        t = {1'b0, acc} + {1'b0, add};
        return t[SUM_W] ? {SUM_W{1'b1}} : t[SUM_W-1:0];
    endfunction

    // largest s with s^2 * na * nb <= dot^2 * 2^30, capped at one
    function automatic logic [SIM_W-1:0] cosine_of_sums(input logic [SUM_W-1:0] dot,
                                                        input logic [SUM_W-1:0] na,
                                                        input logic [SUM_W-1:0] nb);
        logic [127:0] wa;
        logic [127:0] wb;
        logic [127:0] wd;
        logic [127:0] norm_prod;
        logic [127:0] bound;
        logic [127:0] cand_sq;
        logic [16:0]  s;
        logic [16:0]  cand;
        int           k;
        wa = 128'(na);
        wb = 128'(nb);
        wd = 128'(dot);
        norm_prod = wa * wb;
        bound = (wd * wd) << 30;
        s = '0;
        for (k = 15; k >= 0; k--) begin
            cand = s | (17'd1 << k);
            cand_sq = 128'(cand);
            cand_sq = cand_sq * cand_sq;
            if (cand_sq * norm_prod <= bound)
                s = cand;
        end
        if (s > {1'b0, SIM_ONE})
            s = {1'b0, SIM_ONE};
        return s[SIM_W-1:0];
    endfunction

    task automatic flag_bad(input string why);
        if (fail_count < 10)
            $display("[%0t] bad result word: %s", $time, why);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        results_owed = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            dot_acc = '0;
            norm_a_acc = '0;
            norm_b_acc = '0;
            pairs_summed = 0;
            cosine_due.delete();
        end else begin
            // results first, so a word never matches a sum closed at the same edge
            if (m_tvalid && m_tready) begin
                got_word.similarity = m_tdata;
                got_word.undefined = m_tuser;
                if (cosine_due.size() == 0) begin
                    flag_bad($sformatf("unexpected, got sim %0d undef %0b",
                                       got_word.similarity, got_word.undefined));
                end else begin
                    want_word = cosine_due.pop_front();
                    if (got_word != want_word)
                        flag_bad($sformatf("expected sim %0d undef %0b, got sim %0d undef %0b",
                                           want_word.similarity, want_word.undefined,
                                           got_word.similarity, got_word.undefined));
                end
            end
            if (s_tvalid && s_tready) begin
                a_elem = s_tdata[15:0];
                b_elem = s_tdata[31:16];
                if (pairs_summed < MAX_ELEMENTS) begin
                    prod_ab = SUM_W'(a_elem) * SUM_W'(b_elem);
                    prod_aa = SUM_W'(a_elem) * SUM_W'(a_elem);
                    prod_bb = SUM_W'(b_elem) * SUM_W'(b_elem);
                    dot_acc = sat_sum(dot_acc, prod_ab);
                    norm_a_acc = sat_sum(norm_a_acc, prod_aa);
                    norm_b_acc = sat_sum(norm_b_acc, prod_bb);
                    pairs_summed++;
                end
                if (s_tlast) begin
                    if (norm_a_acc == '0 || norm_b_acc == '0) begin
                        want_word.similarity = '0;
                        want_word.undefined = 1'b1;
                    end else begin
                        want_word.similarity = cosine_of_sums(dot_acc, norm_a_acc, norm_b_acc);
                        want_word.undefined = 1'b0;
                    end
                    cosine_due = {cosine_due, want_word};
                    dot_acc = '0;
                    norm_a_acc = '0;
                    norm_b_acc = '0;
                    pairs_summed = 0;
                end
            end
        end
        results_owed = cosine_due.size();
    end

endmodule

[test/tb.sv]
`timescale 1ns / 100ps

module tb;
    import cossim_pkg::*;

    // how the b element of a random vector relates to its a element
    typedef enum int {
        PAIR_FREE,
        PAIR_SAME,
        PAIR_NEAR,
        PAIR_SCALED
    } pair_shape_e;

    localparam int PAIR_TARGET = 1150;   // least number of input words in the whole run
    localparam int QUIET_AFTER = 1000;   // no idling once this many words went in

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;    // elem_a [15:0], elem_b [31:16]
    logic        s_tlast;    // last_pair
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;    // similarity [15:0]
    logic        m_tuser;    // undefined

    int fail_count;
    int results_owed;
    int pairs_sent = 0;
    int gap_pct = 10;        // chance of an input gap after each word
    int stall_pct = 5;       // chance per cycle that a result stall starts
    bit quiet_tail = 1'b0;

    // 4 ns period
    always #2 aclk = ~aclk;

    cosine_similarity dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    cosine_similarity_checker check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    // one element pair; holds the word until it is taken, then maybe idles a burst
    task automatic send_pair(input logic [15:0] a, input logic [15:0] b, input logic last);
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pairs_sent++;
        // tvalid only drops when a gap really follows, never low-then-high in one step
        if (!quiet_tail && $urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    endtask

    // element weights lean toward zero, full scale, tiny and one-hot values
    function automatic logic [15:0] pick_elem();
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = 16'hFFFF;
            2: v = 16'($urandom_range(0, 255));
            3: v = 16'h1 << $urandom_range(0, 15);
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    // one random vector pair; some run past MAX_ELEMENTS so the tail is dropped
    task automatic send_vector();
        int          len;
        int          k;
        pair_shape_e shape;
        logic [15:0] a;
        logic [15:0] b;
        len = ($urandom_range(0, 7) == 0) ? int'($urandom_range(MAX_ELEMENTS_DEFAULT + 1, 24))
                                          : int'($urandom_range(1, MAX_ELEMENTS_DEFAULT));
        shape = pair_shape_e'($urandom_range(PAIR_FREE, PAIR_SCALED));
        // idling density changes from vector to vector, zero included
        case ($urandom_range(0, 2))
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 10; stall_pct = 3;  end
            default: begin gap_pct = 35; stall_pct = 12; end
        endcase
        for (k = 0; k < len; k++) begin
            quiet_tail = (pairs_sent >= QUIET_AFTER);
            a = pick_elem();
            case (shape)
                PAIR_SAME:   b = a;
                PAIR_NEAR:   b = a + 16'($urandom_range(0, 15));
                PAIR_SCALED: b = a >> $urandom_range(1, 4);
                default:     b = pick_elem();
            endcase
            send_pair(a, b, k == len - 1);
        end
    endtask

    // result side: random stall bursts, none in the tail
    initial begin
        m_tready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    initial begin
        int k;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        aresetn  <= 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // full scale on both sides, cosine exactly one
        send_pair(16'hFFFF, 16'hFFFF, 1'b1);
        // zero norm on a, on b, on both
        send_pair(16'h0000, 16'h1234, 1'b1);
        send_pair(16'hFFFF, 16'h0000, 1'b1);
        send_pair(16'h0000, 16'h0000, 1'b1);
        // orthogonal vectors: defined, cosine zero
        send_pair(16'h8000, 16'h0000, 1'b0);
        send_pair(16'h0000, 16'h8000, 1'b1);
        // parallel vectors with the smallest weights
        send_pair(16'h0001, 16'h0002, 1'b0);
        send_pair(16'h0002, 16'h0004, 1'b1);
        // seventeenth pair is past the limit and must not pull the cosine below one
        for (k = 0; k < MAX_ELEMENTS_DEFAULT; k++)
            send_pair(16'h1000, 16'h1000, 1'b0);
        send_pair(16'hFFFF, 16'h0000, 1'b1);

        // random vectors, always ending on a closed vector pair
        while (pairs_sent < PAIR_TARGET)
            send_vector();
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        // let the checker book the last word, then drain
        @(posedge aclk);
        wait (results_owed == 0);
        repeat (120) @(posedge aclk);
        if (fail_count == 0)
            $display("cosine_similarity: match");
        else
            $display("cosine_similarity: mismatch");
        $finish;
    end

    // hard stop well past the slowest legal run
    initial begin
        #4000000;
        $display("cosine_similarity: mismatch");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/cossim_pkg.sv
rtl/core/cossim_front.sv
rtl/core/cossim_queue.sv
rtl/core/cossim_back.sv
rtl/core/cosine_similarity.sv
test/cosine_similarity_checker.sv
test/tb.sv
